>>> rtl/periodic_event_table_scheduler_assert.svh
// Assertion macros for the scheduler RTL.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef PERIODIC_EVENT_TABLE_SCHEDULER_ASSERT_SVH
`define PERIODIC_EVENT_TABLE_SCHEDULER_ASSERT_SVH
// Implication checked in the same cycle.
`define PETS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Implication checked in the cycle after the antecedent.
`define PETS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/pets_pkg.sv
// Package for the periodic event table scheduler: request codes, status codes,
// queue item and table entry types, and the back-end state type. No dependencies.
package pets_pkg;

  localparam int MaxEventsDefault = 16;
  localparam int ResultCap        = 16;
  localparam int QueueDepth       = 2;

  // Request codes
  localparam logic [3:0] REQ_TICK      = 4'd0;
  localparam logic [3:0] REQ_ADD_IMM   = 4'd1;
  localparam logic [3:0] REQ_ADD_SIM   = 4'd2;
  localparam logic [3:0] REQ_ADD_MIS   = 4'd3;
  localparam logic [3:0] REQ_ADD_EPO   = 4'd4;
  localparam logic [3:0] REQ_REMOVE    = 4'd5;
  localparam logic [3:0] REQ_SET_START = 4'd6;
  localparam logic [3:0] REQ_SET_CYCLE = 4'd7;
  localparam logic [3:0] REQ_SET_EXEC  = 4'd8;

  // Time base selectors
  localparam logic [1:0] BASE_SIM = 2'd0;
  localparam logic [1:0] BASE_EPO = 2'd1;
  localparam logic [1:0] BASE_MIS = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NONE     = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [32:0] LIM_UNLIMITED = '1;
  localparam logic [32:0] COUNT_TOP     = 33'h0_FFFF_FFFF;
  localparam logic [63:0] TIME_UNSET    = '1;

  typedef enum logic [1:0] {
    K_TICK,
    K_ADD,
    K_LOOKUP,
    K_OTHER
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  req_type;
    logic [31:0] event_id;
    logic [1:0]  time_base;
    logic [63:0] start_time;
    logic [63:0] cycle_time;
    logic [32:0] repeat_limit;
    logic [63:0] sim_now;
    logic [63:0] epoch_now;
    logic [63:0] mission_now;
  } req_t;

  typedef struct packed {
    logic [31:0] id;
    logic [63:0] sim_start;
    logic [63:0] epoch_start;
    logic [63:0] mission_start;
    logic [63:0] period;
    logic [32:0] fire_limit;
    logic [32:0] fired_count;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_EVAL,
    S_MUL2,
    S_SUM,
    S_CMP,
    S_FIN,
    S_SET,
    S_NF,
    S_SH,
    S_SHW
  } bstate_t;

endpackage

>>> rtl/pets_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pets_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/pets_front.sv
// Front end: unpacks an input transaction and classifies the request.
// Depends on pets_pkg.
module pets_front (
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [3:0]       in_tuser,
  input  logic [391:0]     in_tdata,
  input  logic             q_full,
  output logic             q_push,
  output pets_pkg::req_t   q_item
);

  pets_pkg::kind_t kind;

  // Classify the request code.
  always_comb begin
    case (in_tuser)
      pets_pkg::REQ_TICK:      kind = pets_pkg::K_TICK;
      pets_pkg::REQ_ADD_IMM,
      pets_pkg::REQ_ADD_SIM,
      pets_pkg::REQ_ADD_MIS,
      pets_pkg::REQ_ADD_EPO:   kind = pets_pkg::K_ADD;
      pets_pkg::REQ_REMOVE,
      pets_pkg::REQ_SET_START,
      pets_pkg::REQ_SET_CYCLE,
      pets_pkg::REQ_SET_EXEC:  kind = pets_pkg::K_LOOKUP;
      default:                 kind = pets_pkg::K_OTHER;
    endcase
  end

  // Unpack the payload into a queue item.
  always_comb begin
    q_item.kind         = kind;
    q_item.req_type     = in_tuser;
    q_item.event_id     = in_tdata[31:0];
    q_item.time_base    = in_tdata[33:32];
    q_item.start_time   = in_tdata[97:34];
    q_item.cycle_time   = in_tdata[161:98];
    q_item.repeat_limit = in_tdata[194:162];
    q_item.sim_now      = in_tdata[258:195];
    q_item.epoch_now    = in_tdata[322:259];
    q_item.mission_now  = in_tdata[386:323];
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

endmodule

>>> rtl/pets_queue.sv
// Short request queue between front and back end.
// Depends on pets_pkg.
module pets_queue #(
  parameter int DEPTH = pets_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pets_pkg::req_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output pets_pkg::req_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pets_pkg::req_t slot_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic do_push, do_pop;

  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign full     = (fill_r == CW'(DEPTH));
  assign valid    = (fill_r != '0);
  assign pop_item = slot_r[rptr_r];

  // Pointer and fill update.
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    fill_nxt = fill_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (!do_push && do_pop) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/pets_back.sv
// Back end: holds the event table in a RAM and executes queued requests.
// Depends on pets_pkg, pets_ram and the assertion macro header.
`include "periodic_event_table_scheduler_assert.svh"
module pets_back #(
  parameter int MAX_EVENTS = pets_pkg::MaxEventsDefault
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  pets_pkg::req_t q_item,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [1:0]     out_status,
  output logic [31:0]    out_id,
  output logic           out_last
);

  localparam int AW = $clog2(MAX_EVENTS);
  localparam int CW = $clog2(MAX_EVENTS + 1);
  localparam int NW = $clog2(pets_pkg::ResultCap + 1);
  localparam int EW = $bits(pets_pkg::entry_t);

  pets_pkg::bstate_t st_r, st_nxt;
  pets_pkg::req_t    req_r, req_nxt;
  pets_pkg::entry_t  ent_r, ent_nxt, rdata, wdata, newent, setent;
  logic [CW-1:0]     cnt_r, cnt_nxt, idx_r, idx_nxt, idx_inc;
  logic [31:0]       next_id_r, next_id_nxt, pend_id_r, pend_id_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [NW-1:0]     nfire_r, nfire_nxt;
  logic signed [65:0] pa_r, pa_nxt;
  logic signed [64:0] pb_r, pb_nxt;
  logic signed [96:0] prod_r, prod_nxt;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [EW-1:0]     rdata_raw;
  logic              slot_free, emit, emit_last;
  logic [1:0]        emit_status;
  logic [31:0]       emit_id;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [31:0]       out_id_r;
  logic              out_last_r;
  logic              idx_is_last, id_match, cap_hit;
  logic              live, due, fire, fire_stall;
  logic [63:0]       now_sel, start_sel;
  logic signed [97:0] next_time;
  logic [32:0]       cnt_inc;

  pets_ram #(.WIDTH(EW), .DEPTH(MAX_EVENTS)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata_raw)
  );

  assign rdata       = pets_pkg::entry_t'(rdata_raw);
  assign slot_free   = !out_valid_r || out_tready;
  assign idx_inc     = idx_r + 1'b1;
  assign idx_is_last = (idx_inc == cnt_r);
  assign id_match    = (rdata.id == req_r.event_id);
  assign cap_hit     = (nfire_r == NW'(pets_pkg::ResultCap - 1));
  assign raddr       = (st_r == pets_pkg::S_SH) ? idx_inc[AW-1:0] : idx_r[AW-1:0];
  assign q_pop       = (st_r == pets_pkg::S_IDLE) && q_valid && slot_free;

  // Time base choice and firing test for the entry under evaluation.
  always_comb begin
    if (ent_r.sim_start != pets_pkg::TIME_UNSET) begin
      now_sel = req_r.sim_now;
      start_sel = ent_r.sim_start;
    end else if (ent_r.epoch_start != pets_pkg::TIME_UNSET) begin
      now_sel = req_r.epoch_now;
      start_sel = ent_r.epoch_start;
    end else if (ent_r.mission_start != pets_pkg::TIME_UNSET) begin
      now_sel = req_r.mission_now;
      start_sel = ent_r.mission_start;
    end else begin
      now_sel = pets_pkg::TIME_UNSET;
      start_sel = pets_pkg::TIME_UNSET;
    end
    if (ent_r.period[63]) begin
      next_time = 98'($signed(start_sel));
    end else begin
      next_time = 98'(prod_r) + 98'($signed(start_sel));
    end
    due  = (98'($signed(now_sel)) >= next_time);
    live = (ent_r.fire_limit == pets_pkg::LIM_UNLIMITED) ||
           ($signed(ent_r.fired_count) < $signed(ent_r.fire_limit));
    fire = live && due;
    fire_stall = fire && pend_v_r && !slot_free;
    cnt_inc = (ent_r.fired_count == pets_pkg::COUNT_TOP) ? ent_r.fired_count
                                                         : ent_r.fired_count + 1'b1;
  end

  // New entry for an add request.
  always_comb begin
    newent.id            = next_id_r;
    newent.sim_start     = pets_pkg::TIME_UNSET;
    newent.epoch_start   = pets_pkg::TIME_UNSET;
    newent.mission_start = pets_pkg::TIME_UNSET;
    newent.period        = q_item.cycle_time;
    newent.fire_limit    = q_item.repeat_limit;
    newent.fired_count   = '0;
    case (q_item.req_type)
      pets_pkg::REQ_ADD_IMM: begin
        newent.sim_start  = q_item.sim_now;
        newent.period     = '1;
        newent.fire_limit = 33'd1;
      end
      pets_pkg::REQ_ADD_SIM: begin
        newent.sim_start = ($signed(q_item.start_time) < $signed(q_item.sim_now)) ?
                           q_item.sim_now : q_item.start_time;
      end
      pets_pkg::REQ_ADD_MIS: newent.mission_start = q_item.start_time;
      default:               newent.epoch_start = q_item.start_time;
    endcase
  end

  // Modified entry for a set request.
  always_comb begin
    setent = ent_r;
    case (req_r.req_type)
      pets_pkg::REQ_SET_START: begin
        case (req_r.time_base)
          pets_pkg::BASE_SIM: setent.sim_start = req_r.start_time;
          pets_pkg::BASE_EPO: setent.epoch_start = req_r.start_time;
          pets_pkg::BASE_MIS: setent.mission_start = req_r.start_time;
          default:            setent = ent_r;
        endcase
      end
      pets_pkg::REQ_SET_CYCLE: setent.period = req_r.cycle_time;
      pets_pkg::REQ_SET_EXEC:  setent.fired_count = req_r.repeat_limit;
      default:                 setent = ent_r;
    endcase
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      pets_pkg::S_IDLE: begin
        if (q_pop) begin
          case (q_item.kind)
            pets_pkg::K_TICK:   st_nxt = (cnt_r == '0) ? pets_pkg::S_FIN : pets_pkg::S_RD;
            pets_pkg::K_LOOKUP: st_nxt = (cnt_r == '0) ? pets_pkg::S_NF : pets_pkg::S_RD;
            default:            st_nxt = pets_pkg::S_IDLE;
          endcase
        end
      end
      pets_pkg::S_RD: st_nxt = pets_pkg::S_EVAL;
      pets_pkg::S_EVAL: begin
        if (req_r.kind == pets_pkg::K_TICK) begin
          st_nxt = pets_pkg::S_MUL2;
        end else if (id_match) begin
          st_nxt = (req_r.req_type == pets_pkg::REQ_REMOVE) ? pets_pkg::S_SH : pets_pkg::S_SET;
        end else begin
          st_nxt = idx_is_last ? pets_pkg::S_NF : pets_pkg::S_RD;
        end
      end
      pets_pkg::S_MUL2: st_nxt = pets_pkg::S_SUM;
      pets_pkg::S_SUM:  st_nxt = pets_pkg::S_CMP;
      pets_pkg::S_CMP: begin
        if (!fire_stall) begin
          st_nxt = (idx_is_last || (fire && cap_hit)) ? pets_pkg::S_FIN : pets_pkg::S_RD;
        end
      end
      pets_pkg::S_FIN,
      pets_pkg::S_SET,
      pets_pkg::S_NF: st_nxt = slot_free ? pets_pkg::S_IDLE : st_r;
      pets_pkg::S_SH: begin
        if (idx_inc < cnt_r) begin
          st_nxt = pets_pkg::S_SHW;
        end else if (slot_free) begin
          st_nxt = pets_pkg::S_IDLE;
        end
      end
      pets_pkg::S_SHW: st_nxt = pets_pkg::S_SH;
      default: st_nxt = pets_pkg::S_IDLE;
    endcase
  end

  // Datapath, table writes and result emission.
  always_comb begin
    req_nxt     = req_r;
    ent_nxt     = ent_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    next_id_nxt = next_id_r;
    pend_id_nxt = pend_id_r;
    pend_v_nxt  = pend_v_r;
    nfire_nxt   = nfire_r;
    pa_nxt      = pa_r;
    pb_nxt      = pb_r;
    prod_nxt    = prod_r;
    we          = 1'b0;
    waddr       = idx_r[AW-1:0];
    wdata       = ent_r;
    emit        = 1'b0;
    emit_status = pets_pkg::ST_OK;
    emit_id     = '0;
    emit_last   = 1'b1;
    case (st_r)
      pets_pkg::S_IDLE: begin
        if (q_pop) begin
          req_nxt    = q_item;
          idx_nxt    = '0;
          nfire_nxt  = '0;
          pend_v_nxt = 1'b0;
          case (q_item.kind)
            pets_pkg::K_ADD: begin
              emit = 1'b1;
              if (cnt_r >= CW'(MAX_EVENTS)) begin
                emit_status = pets_pkg::ST_FULL;
              end else begin
                we          = 1'b1;
                waddr       = cnt_r[AW-1:0];
                wdata       = newent;
                cnt_nxt     = cnt_r + 1'b1;
                next_id_nxt = next_id_r + 1'b1;
                emit_id     = next_id_r;
              end
            end
            pets_pkg::K_OTHER: emit = 1'b1;
            default: emit = 1'b0;
          endcase
        end
      end
      pets_pkg::S_EVAL: begin
        ent_nxt = rdata;
        pa_nxt  = $signed(rdata.fired_count) * $signed({1'b0, rdata.period[31:0]});
        if (req_r.kind != pets_pkg::K_TICK && !id_match) begin
          idx_nxt = idx_inc;
        end
      end
      pets_pkg::S_MUL2: pb_nxt = $signed(ent_r.fired_count) * $signed(ent_r.period[63:32]);
      pets_pkg::S_SUM:  prod_nxt = 97'(pa_r) + (97'(pb_r) <<< 32);
      pets_pkg::S_CMP: begin
        if (!fire_stall) begin
          idx_nxt = idx_inc;
          if (fire) begin
            emit        = pend_v_r;
            emit_id     = pend_id_r;
            emit_last   = 1'b0;
            pend_id_nxt = ent_r.id;
            pend_v_nxt  = 1'b1;
            nfire_nxt   = nfire_r + 1'b1;
            we          = 1'b1;
            wdata       = ent_r;
            wdata.fired_count = cnt_inc;
          end
        end
      end
      pets_pkg::S_FIN: begin
        emit        = slot_free;
        emit_status = pend_v_r ? pets_pkg::ST_OK : pets_pkg::ST_NONE;
        emit_id     = pend_v_r ? pend_id_r : '0;
      end
      pets_pkg::S_SET: begin
        emit    = slot_free;
        emit_id = req_r.event_id;
        we      = slot_free;
        wdata   = setent;
      end
      pets_pkg::S_NF: begin
        emit        = slot_free;
        emit_status = pets_pkg::ST_NOTFOUND;
        emit_id     = req_r.event_id;
      end
      pets_pkg::S_SH: begin
        if (!(idx_inc < cnt_r) && slot_free) begin
          cnt_nxt = cnt_r - 1'b1;
          emit    = 1'b1;
          emit_id = req_r.event_id;
        end
      end
      pets_pkg::S_SHW: begin
        we      = 1'b1;
        wdata   = rdata;
        idx_nxt = idx_inc;
      end
      default: emit = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= pets_pkg::S_IDLE;
      cnt_r       <= '0;
      next_id_r   <= '0;
      pend_v_r    <= 1'b0;
      nfire_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      cnt_r     <= cnt_nxt;
      next_id_r <= next_id_nxt;
      pend_v_r  <= pend_v_nxt;
      nfire_r   <= nfire_nxt;
      idx_r     <= idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    ent_r     <= ent_nxt;
    pend_id_r <= pend_id_nxt;
    pa_r      <= pa_nxt;
    pb_r      <= pb_nxt;
    prod_r    <= prod_nxt;
    if (emit) begin
      out_status_r <= emit_status;
      out_id_r     <= emit_id;
      out_last_r   <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_id     = out_id_r;
  assign out_last   = out_last_r;

  `PETS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CW'(MAX_EVENTS), "entry count above table size")
  `PETS_ASSERT_IMP(a_rd_idx, st_r == pets_pkg::S_RD, idx_r < cnt_r, "table read beyond last entry")
  `PETS_ASSERT_IMP(a_fire_cap, 1'b1, nfire_r <= NW'(pets_pkg::ResultCap), "too many firings")
  `PETS_ASSERT_NXT(a_emit_hold, emit, out_valid_r, "emitted result not registered")

endmodule

>>> rtl/periodic_event_table_scheduler.sv
// Top level of the periodic event table scheduler.
// Depends on pets_pkg, pets_front, pets_queue and pets_back.
//
//  channel | direction | tdata                       | tuser     | tlast
//  in_     | slave     | request fields (see below)  | req_type  | -
//  out_    | master    | result_id                   | status    | last
//
// A request waits in a two-entry queue, so the input side keeps taking
// transactions while the table unit is busy.
// A tick takes each table entry in turn (one RAM read, a 33x33 and a 33x32
// partial product, a sum and a compare) and then finishes with a last result.
// Add and unknown requests are answered from the idle state; remove and set
// search the table entry by entry, and remove then closes up the gap.
// Reset is synchronous and active low; the table contents need no clearing.
// A stalled result holds in the output register and stops the table unit.
module periodic_event_table_scheduler #(
  parameter int MAX_EVENTS = pets_pkg::MaxEventsDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // req_type [3:0]
  input  logic [3:0]   in_tuser,
  // event_id [31:0], time_base [33:32], start_time [97:34], cycle_time [161:98],
  // repeat_limit [194:162], sim_now [258:195], epoch_now [322:259],
  // mission_now [386:323], zero fill above
  input  logic [391:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_id [31:0]
  output logic [31:0]  out_tdata,
  // status [1:0]
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);

  pets_pkg::req_t push_item, pop_item;
  logic q_push, q_full, q_pop, q_valid;

  pets_front u_front (
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tuser (in_tuser),
    .in_tdata (in_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  pets_queue #(.DEPTH(pets_pkg::QueueDepth)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_item (pop_item)
  );

  pets_back #(.MAX_EVENTS(MAX_EVENTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (pop_item),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_status(out_tuser),
    .out_id    (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

>>> bench/periodic_event_table_scheduler_tb.sv
// Self-checking testbench for the periodic event table scheduler.
// Depends on pets_pkg and periodic_event_table_scheduler; predicts every result in place.
module periodic_event_table_scheduler_tb;

  localparam int NumEvents = 16;
  localparam int WatchLimit = 20000;

  typedef struct {
    logic [3:0]  kind;
    logic [31:0] eid;
    logic [1:0]  base;
    logic [63:0] st;
    logic [63:0] cyc;
    logic [32:0] lim;
    logic [63:0] sn;
    logic [63:0] en;
    logic [63:0] mn;
  } sched_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] id;
    logic        last;
  } sched_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [3:0]   in_tuser = '0;
  logic [391:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  // Mirror of the event table.
  logic [31:0] tbl_id    [NumEvents];
  logic [63:0] tbl_sim   [NumEvents];
  logic [63:0] tbl_epo   [NumEvents];
  logic [63:0] tbl_mis   [NumEvents];
  logic [63:0] tbl_per   [NumEvents];
  logic [32:0] tbl_lim   [NumEvents];
  logic [32:0] tbl_cnt   [NumEvents];
  int          tbl_used;
  logic [31:0] id_next;

  sched_res_t expected_results[$];
  int  fail_count = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  fires_seen = 0;
  int  idle_cycles = 0;
  bit  hold_request = 1'b0;
  logic [63:0] clock_now = 64'd0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  periodic_event_table_scheduler DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // Decide whether a table entry is due at the given times, with exact arithmetic.
  function automatic bit entry_due(int i, logic [63:0] sn, logic [63:0] en, logic [63:0] mn);
    logic signed [129:0] now_w, start_w, cnt_w, per_w, next_w;
    logic [63:0] now_v, start_v;
    if (tbl_sim[i] != pets_pkg::TIME_UNSET) begin
      now_v = sn; start_v = tbl_sim[i];
    end else if (tbl_epo[i] != pets_pkg::TIME_UNSET) begin
      now_v = en; start_v = tbl_epo[i];
    end else if (tbl_mis[i] != pets_pkg::TIME_UNSET) begin
      now_v = mn; start_v = tbl_mis[i];
    end else begin
      now_v = pets_pkg::TIME_UNSET; start_v = pets_pkg::TIME_UNSET;
    end
    now_w = $signed(now_v);
    start_w = $signed(start_v);
    cnt_w = $signed(tbl_cnt[i]);
    per_w = $signed(tbl_per[i]);
    if (!tbl_per[i][63]) next_w = cnt_w * per_w + start_w;
    else next_w = start_w;
    return now_w >= next_w;
  endfunction

  function automatic int find_event(logic [31:0] id);
    for (int i = 0; i < tbl_used; i++) if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void push_result(logic [1:0] s, logic [31:0] id, logic l);
    sched_res_t r;
    r.status = s; r.id = id; r.last = l;
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Apply one accepted request to the mirror and queue the results it causes.
  function automatic void schedule_request(sched_req_t q);
    int n, idx;
    bit live;
    n = 0;
    if (q.kind == pets_pkg::REQ_TICK) begin
      for (int i = 0; i < tbl_used && n < pets_pkg::ResultCap; i++) begin
        live = (tbl_lim[i] == pets_pkg::LIM_UNLIMITED) ||
               ($signed(tbl_cnt[i]) < $signed(tbl_lim[i]));
        if (live && entry_due(i, q.sn, q.en, q.mn)) begin
          if (tbl_cnt[i] != pets_pkg::COUNT_TOP) tbl_cnt[i] = tbl_cnt[i] + 33'd1;
          push_result(pets_pkg::ST_OK, tbl_id[i], 1'b0);
          n++;
        end
      end
      if (n == 0) push_result(pets_pkg::ST_NONE, 32'd0, 1'b1);
      else expected_results[$].last = 1'b1;
    end else if (q.kind >= pets_pkg::REQ_ADD_IMM && q.kind <= pets_pkg::REQ_ADD_EPO) begin
      if (tbl_used >= NumEvents) begin
        push_result(pets_pkg::ST_FULL, 32'd0, 1'b1);
      end else begin
        idx = tbl_used;
        tbl_id[idx] = id_next;
        tbl_sim[idx] = pets_pkg::TIME_UNSET;
        tbl_epo[idx] = pets_pkg::TIME_UNSET;
        tbl_mis[idx] = pets_pkg::TIME_UNSET;
        tbl_per[idx] = q.cyc; tbl_lim[idx] = q.lim; tbl_cnt[idx] = '0;
        case (q.kind)
          pets_pkg::REQ_ADD_IMM: begin
            tbl_sim[idx] = q.sn; tbl_per[idx] = pets_pkg::TIME_UNSET; tbl_lim[idx] = 33'd1;
          end
          pets_pkg::REQ_ADD_SIM: tbl_sim[idx] = ($signed(q.st) < $signed(q.sn)) ? q.sn : q.st;
          pets_pkg::REQ_ADD_MIS: tbl_mis[idx] = q.st;
          default:               tbl_epo[idx] = q.st;
        endcase
        tbl_used++;
        push_result(pets_pkg::ST_OK, id_next, 1'b1);
        id_next = id_next + 32'd1;
      end
    end else if (q.kind >= pets_pkg::REQ_REMOVE && q.kind <= pets_pkg::REQ_SET_EXEC) begin
      idx = find_event(q.eid);
      if (idx < 0) begin
        push_result(pets_pkg::ST_NOTFOUND, q.eid, 1'b1);
      end else begin
        case (q.kind)
          pets_pkg::REQ_REMOVE: begin
            for (int j = idx; j + 1 < tbl_used; j++) begin
              tbl_id[j] = tbl_id[j+1]; tbl_sim[j] = tbl_sim[j+1]; tbl_epo[j] = tbl_epo[j+1];
              tbl_mis[j] = tbl_mis[j+1]; tbl_per[j] = tbl_per[j+1];
              tbl_lim[j] = tbl_lim[j+1]; tbl_cnt[j] = tbl_cnt[j+1];
            end
            tbl_used--;
          end
          pets_pkg::REQ_SET_START: begin
            if (q.base == pets_pkg::BASE_SIM) tbl_sim[idx] = q.st;
            else if (q.base == pets_pkg::BASE_EPO) tbl_epo[idx] = q.st;
            else if (q.base == pets_pkg::BASE_MIS) tbl_mis[idx] = q.st;
          end
          pets_pkg::REQ_SET_CYCLE: tbl_per[idx] = q.cyc;
          default:                 tbl_cnt[idx] = q.lim;
        endcase
        push_result(pets_pkg::ST_OK, q.eid, 1'b1);
      end
    end else begin
      push_result(pets_pkg::ST_OK, 32'd0, 1'b1);
    end
  endfunction

  // Offer one request after a random gap and predict it once it is accepted.
  task automatic send_request(sched_req_t q);
    repeat ($urandom_range(0, 4)) @(negedge clk);
    in_tuser = q.kind;
    in_tdata = {5'd0, q.mn, q.en, q.sn, q.lim, q.cyc, q.st, q.base, q.eid};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    schedule_request(q);
    items_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  function automatic sched_req_t make_req(logic [3:0] kind);
    sched_req_t q;
    q.kind = kind; q.eid = '0; q.base = pets_pkg::BASE_SIM;
    q.st = pets_pkg::TIME_UNSET; q.cyc = pets_pkg::TIME_UNSET;
    q.lim = pets_pkg::LIM_UNLIMITED; q.sn = clock_now; q.en = clock_now; q.mn = clock_now;
    return q;
  endfunction

  // Mostly times near the running clock, sometimes unset or anywhere in range.
  function automatic logic [63:0] rand_time();
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) return pets_pkg::TIME_UNSET;
    if (p == 1) return {$urandom, $urandom};
    if (p == 2) return {1'b0, {63{1'b1}}};
    return clock_now + 64'($urandom_range(0, 40)) - 64'd10;
  endfunction

  function automatic logic [32:0] rand_limit();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return pets_pkg::LIM_UNLIMITED;
    if (p == 1) return {1'($urandom_range(0, 1)), $urandom};
    return 33'($urandom_range(0, 6));
  endfunction

  function automatic logic [31:0] pick_id();
    if (tbl_used > 0 && $urandom_range(0, 7) != 0) return tbl_id[$urandom_range(0, tbl_used - 1)];
    return $urandom;
  endfunction

  task automatic tick_now();
    send_request(make_req(pets_pkg::REQ_TICK));
  endtask

  // Every add flavour, including the clamp of a simulation add to the present.
  task automatic test_adds();
    sched_req_t q;
    clock_now = 64'd100;
    send_request(make_req(pets_pkg::REQ_ADD_IMM));
    q = make_req(pets_pkg::REQ_ADD_SIM); q.st = 64'd20; q.cyc = 64'd10; q.lim = 33'd3;
    send_request(q);
    q = make_req(pets_pkg::REQ_ADD_MIS); q.st = 64'd150; q.cyc = 64'd0;
    send_request(q);
    q = make_req(pets_pkg::REQ_ADD_EPO); q.st = {1'b0, {63{1'b1}}}; q.cyc = {1'b0, {63{1'b1}}};
    send_request(q);
    q = make_req(pets_pkg::REQ_ADD_EPO); q.st = pets_pkg::TIME_UNSET;
    q.cyc = pets_pkg::TIME_UNSET;
    send_request(q);
    tick_now();
  endtask

  // Ticks that move each time base, including all-ones and negative times.
  task automatic test_tick_bases();
    sched_req_t q;
    clock_now = 64'd160;
    tick_now();
    q = make_req(pets_pkg::REQ_TICK); q.sn = pets_pkg::TIME_UNSET;
    q.en = {1'b0, {63{1'b1}}}; q.mn = 64'h8000_0000_0000_0000;
    send_request(q);
    tick_now();
  endtask

  // Field writes, the unused time base, the count at its top and unknown ids.
  task automatic test_setters();
    sched_req_t q;
    for (int b = 0; b < 4; b++) begin
      q = make_req(pets_pkg::REQ_SET_START); q.eid = 32'd2; q.base = 2'(b);
      q.st = 64'd50 + 64'(b);
      send_request(q);
    end
    q = make_req(pets_pkg::REQ_SET_CYCLE); q.eid = 32'd2; q.cyc = 64'd1;
    send_request(q);
    q = make_req(pets_pkg::REQ_SET_EXEC); q.eid = 32'd4; q.lim = pets_pkg::COUNT_TOP;
    send_request(q);
    q = make_req(pets_pkg::REQ_SET_EXEC); q.eid = 32'd3; q.lim = 33'h1_0000_0000;
    send_request(q);
    q = make_req(pets_pkg::REQ_SET_CYCLE); q.eid = 32'hFFFF_FFFF;
    send_request(q);
    tick_now();
    tick_now();
  endtask

  // Fill the table, overflow it, and tick with a full table.
  task automatic test_full_and_cap();
    sched_req_t q;
    while (tbl_used < NumEvents + 1) begin
      q = make_req(pets_pkg::REQ_ADD_SIM); q.st = 64'd0; q.cyc = 64'd0;
      send_request(q);
      if (tbl_used == NumEvents) begin
        send_request(q);
        break;
      end
    end
    tick_now();
    tick_now();
  endtask

  // Removal at the head, middle and tail, a missing id, and the unknown request codes.
  task automatic test_remove();
    sched_req_t q;
    q = make_req(pets_pkg::REQ_REMOVE);
    q.eid = tbl_id[0]; send_request(q);
    q.eid = tbl_id[tbl_used / 2]; send_request(q);
    q.eid = tbl_id[tbl_used - 1]; send_request(q);
    q.eid = 32'hDEAD_0000; send_request(q);
    for (int k = 9; k < 16; k++) send_request(make_req(4'(k)));
  endtask

  // Random traffic with most requests addressing live entries.
  task automatic test_random_traffic(int count);
    sched_req_t q;
    int p;
    for (int n = 0; n < count; n++) begin
      p = $urandom_range(0, 99);
      if (p < 30) q = make_req(pets_pkg::REQ_TICK);
      else if (p < 55) q = make_req(4'($urandom_range(1, 4)));
      else if (p < 67) q = make_req(pets_pkg::REQ_REMOVE);
      else if (p < 97) q = make_req(4'($urandom_range(6, 8)));
      else q = make_req(4'($urandom_range(9, 15)));
      if (tbl_used >= NumEvents - 1 && q.kind >= pets_pkg::REQ_ADD_IMM &&
          q.kind <= pets_pkg::REQ_ADD_EPO && $urandom_range(0, 3) != 0) begin
        q.kind = pets_pkg::REQ_REMOVE;
      end
      q.eid = pick_id();
      q.base = 2'($urandom_range(0, 3));
      q.st = rand_time();
      q.cyc = ($urandom_range(0, 4) == 0) ? rand_time() : 64'($urandom_range(0, 12));
      q.lim = rand_limit();
      q.sn = rand_time(); q.en = rand_time(); q.mn = rand_time();
      send_request(q);
      clock_now = clock_now + 64'($urandom_range(0, 6));
    end
  endtask

  // The receiver stalls for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_request = 1'b1;
    test_random_traffic(30);
  endtask

  // Receiver: random stall before each result, or one long hold when asked.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready = 1'b0;
        repeat (400) @(negedge clk);
        hold_request = 1'b0;
      end
      out_tready = 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Compare each result transaction against the oldest prediction.
  always @(posedge clk) begin
    sched_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d id %0h", out_tuser, out_tdata);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (e.status == pets_pkg::ST_OK && out_tuser == pets_pkg::ST_OK) fires_seen++;
        if (out_tuser !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_tuser);
          fail_count++;
        end
        if (out_tdata !== e.id) begin
          $error("result_id: expected %0h, got %0h", e.id, out_tdata);
          fail_count++;
        end
        if (out_tlast !== e.last) begin
          $error("last: expected %0b, got %0b", e.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("periodic_event_table_scheduler test failed");
      $finish;
    end
  end

  initial begin
    tbl_used = 0;
    id_next = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_adds();
    test_tick_bases();
    test_setters();
    test_full_and_cap();
    test_remove();
    test_random_traffic(200);
    test_backpressure();
    test_random_traffic(200);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (expected_results.size() != 0) fail_count++;
    $display("Sent %0d requests covering adds, removes, field writes and ticks;", items_sent);
    $display("checked %0d results, %0d of them firings or acknowledgements.", results_seen,
             fires_seen);
    if (fail_count == 0) begin
      $display("periodic_event_table_scheduler test passed");
    end else begin
      $display("periodic_event_table_scheduler test failed");
    end
    $finish;
  end

endmodule
